// ----- src/ita_pkg.sv -----
// Shared codes, constants, types and tables of the integer-to-ASCII formatter.
package ita_pkg;

   localparam logic [2:0] CMD_UDEC = 3'd0;
   localparam logic [2:0] CMD_SDEC = 3'd1;
   localparam logic [2:0] CMD_HEX2 = 3'd2;
   localparam logic [2:0] CMD_HEX4 = 3'd3;
   localparam logic [2:0] CMD_HEX8 = 3'd4;

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_UPPER = 8'h41;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;
   localparam logic [3:0] NIBBLE_MASK = 4'hF;

   // last nibble index for each hex width
   localparam logic [3:0] HEX2_TOP = 4'd1;
   localparam logic [3:0] HEX4_TOP = 4'd3;
   localparam logic [3:0] HEX8_TOP = 4'd7;

   // [exponent][multiple] = multiple * 10**exponent, 36 bits so 9e9 fits
   typedef logic [15:0][9:0][35:0] mult_table_type;

   function automatic mult_table_type build_mult_table();
      mult_table_type t;
      logic [35:0]    p;
      t = '0;
      p = 36'd1;
      for (int e = 0; e < 10; e++) begin
         for (int m = 0; m < 10; m++) begin
            t[e][m] = p * 36'(m);
         end
         p = p * 36'd10;
      end
      return t;
   endfunction

   localparam mult_table_type POW10_MULT = build_mult_table();

   // Item handed from the prep stage to the character emitter.
   typedef struct packed {
      logic        hex;
      logic        neg;
      logic [31:0] mag;
      logic [3:0]  hex_top;
   } load_type;

   function automatic logic [7:0] hex_char(logic [3:0] nib);
      logic [3:0] n;
      n = nib & NIBBLE_MASK;
      if (n < 4'd10) begin
         return ASCII_ZERO + {4'd0, n};
      end
      return ASCII_UPPER + {4'd0, n - 4'd10};
   endfunction

endpackage

// ----- src/ita_emitter.sv -----
// Character emitter: walks one number's text out, one registered character per cycle.
module ita_emitter (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_valid,
   input  ita_pkg::load_type load,
   output logic              ready,
   output logic              rsp_valid,
   output logic [7:0]        rsp_character,
   output logic              rsp_last_char
);

   logic        active_ff, active_in;
   logic        neg_ff, neg_in;
   logic        hex_ff, hex_in;
   logic [31:0] mag_ff, mag_in;
   logic [3:0]  pos_ff, pos_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_char_ff, rsp_char_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [9:0][35:0] row;
   logic [8:0]       digit_ge;
   logic [3:0]       digit;
   logic [31:0]      rem;
   logic [8:0]       len_ge;
   logic [3:0]       dec_top;
   logic             last_now;
   logic             take;

   always_comb begin
      row = ita_pkg::POW10_MULT[pos_ff];
      // digit = how many multiples of 10**pos fit in the remainder
      for (int m = 1; m < 10; m++) begin
         digit_ge[m-1] = {4'd0, mag_ff} >= row[m];
      end
      digit = 4'($countones(digit_ge));
      rem   = mag_ff - row[digit][31:0];

      // highest nonzero decimal position of a freshly loaded magnitude
      for (int k = 1; k < 10; k++) begin
         len_ge[k-1] = {4'd0, load.mag} >= ita_pkg::POW10_MULT[k][1];
      end
      dec_top = 4'($countones(len_ge));
   end

   assign last_now = active_ff && !neg_ff && (pos_ff == 4'd0);
   assign ready    = !active_ff || last_now;
   assign take     = load_valid && ready;

   always_comb begin
      active_in = active_ff;
      neg_in    = neg_ff;
      hex_in    = hex_ff;
      mag_in    = mag_ff;
      pos_in    = pos_ff;
      if (take) begin
         active_in = 1'b1;
         neg_in    = load.neg;
         hex_in    = load.hex;
         mag_in    = load.mag;
         pos_in    = load.hex ? load.hex_top : dec_top;
      end else if (active_ff) begin
         if (neg_ff) begin
            neg_in = 1'b0;
         end else begin
            if (last_now) begin
               active_in = 1'b0;
            end
            pos_in = pos_ff - 4'd1;
            if (!hex_ff) begin
               mag_in = rem;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = active_ff;
      rsp_last_in  = last_now;
      if (neg_ff) begin
         rsp_char_in = ita_pkg::ASCII_MINUS;
      end else if (hex_ff) begin
         rsp_char_in = ita_pkg::hex_char(mag_ff[{pos_ff[2:0], 2'b00} +: 4]);
      end else begin
         rsp_char_in = ita_pkg::ASCII_ZERO + {4'd0, digit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      hex_ff      <= hex_in;
      mag_ff      <= mag_in;
      pos_ff      <= pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

endmodule

// ----- src/integer_to_ascii_formatter.sv -----
// Top level of the integer-to-ASCII formatter.
//
// Usage: drive req_command and req_value and raise start; the item is taken
// at a rising edge with start high and busy low. Commands: unsigned decimal,
// signed decimal, hex with 2, 4 or 8 digits; any other code is dropped with
// no output. The text comes back one character per cycle on rsp_character,
// marked by rsp_valid for exactly one cycle, with rsp_last_char on the final
// character. The receiver cannot stall, so every strobe is a delivered character.
// Each item passes the input register, the sign/magnitude stage and the
// emitter load before its characters leave the output register, one per cycle.
// The emitter walks an item's characters out, 1 to 11 of them, one per cycle.
// Two items queue in front of it, and its next item loads while its last
// character goes out, so texts of successive items follow with no gap.
// Reset (synchronous, active high) empties the queue and the emitter and
// drops any text in flight; busy is low after reset.
module integer_to_ascii_formatter (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   output logic [7:0]  rsp_character,
   output logic        rsp_last_char
);

   logic        a_valid_ff;
   logic [2:0]  a_cmd_ff;
   logic [31:0] a_value_ff;

   logic              b_valid_ff, b_valid_in;
   ita_pkg::load_type b_ff, b_in;

   logic e_ready;
   logic e_load;
   logic b_free;
   logic accept;
   logic cmd_ok;

   assign e_load = b_valid_ff && e_ready;
   assign b_free = !b_valid_ff || e_load;
   assign busy   = a_valid_ff && !b_free;
   assign accept = start && !busy;

   always_comb begin
      b_in.neg     = (a_cmd_ff == ita_pkg::CMD_SDEC) && a_value_ff[31];
      b_in.mag     = b_in.neg ? (32'd0 - a_value_ff) : a_value_ff;
      b_in.hex     = 1'b0;
      b_in.hex_top = ita_pkg::HEX8_TOP;
      cmd_ok       = 1'b1;
      unique case (a_cmd_ff)
         ita_pkg::CMD_UDEC, ita_pkg::CMD_SDEC: ;
         ita_pkg::CMD_HEX2: begin
            b_in.hex     = 1'b1;
            b_in.hex_top = ita_pkg::HEX2_TOP;
         end
         ita_pkg::CMD_HEX4: begin
            b_in.hex     = 1'b1;
            b_in.hex_top = ita_pkg::HEX4_TOP;
         end
         ita_pkg::CMD_HEX8: begin
            b_in.hex     = 1'b1;
            b_in.hex_top = ita_pkg::HEX8_TOP;
         end
         default: cmd_ok = 1'b0;
      endcase
      b_valid_in = b_free ? (a_valid_ff && cmd_ok) : b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            a_valid_ff <= 1'b1;
         end else if (b_free) begin
            a_valid_ff <= 1'b0;
         end
         b_valid_ff <= b_valid_in;
      end
      if (accept) begin
         a_cmd_ff   <= req_command;
         a_value_ff <= req_value;
      end
      if (b_free) begin
         b_ff <= b_in;
      end
   end

   ita_emitter u_emitter (
      .clock         (clock),
      .reset         (reset),
      .load_valid    (b_valid_ff),
      .load          (b_ff),
      .ready         (e_ready),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_last_char (rsp_last_char)
   );

   // a minus sign always has digits after it
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_character == ita_pkg::ASCII_MINUS) |-> !rsp_last_char)
      else $error("minus sign marked as last character");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_character >= 8'h30 && rsp_character <= 8'h39) ||
                     (rsp_character >= 8'h41 && rsp_character <= 8'h46) ||
                     rsp_character == ita_pkg::ASCII_MINUS))
      else $error("character outside digit, hex letter or minus");

   assert property (@(posedge clock) reset |=> (!rsp_valid && !busy))
      else $error("output or busy active right after reset");

   // a queued item waiting on a full prep stage means the emitter is occupied
   assert property (@(posedge clock) disable iff (reset)
      busy |-> (b_valid_ff && !e_ready))
      else $error("busy while the emitter could take the next item");

endmodule
